// ----- sv/lmn_pkg.sv -----
package lmn_pkg;

   localparam int MAX_NODES  = 15;
   localparam int STAMP_BITS = 16;
   localparam int ID_LIMIT   = (MAX_NODES < 15) ? MAX_NODES : 15;
   localparam int MAP_BITS   = ID_LIMIT + 1;
   localparam int IDX_BITS   = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;
   localparam int CNT_BITS   = 5;
   localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;

   // command codes
   localparam logic [2:0] CMD_RECEIVE = 3'd0;
   localparam logic [2:0] CMD_REQUEST = 3'd1;
   localparam logic [2:0] CMD_RELEASE = 3'd2;
   localparam logic [2:0] CMD_STARTED = 3'd3;
   localparam logic [2:0] CMD_DONE    = 3'd4;

   // message kinds, received and sent
   localparam logic [1:0] MSG_STARTED = 2'd0;
   localparam logic [1:0] MSG_REQUEST = 2'd1;
   localparam logic [1:0] MSG_REPLY   = 2'd2;
   localparam logic [1:0] MSG_DONE    = 2'd3;

   // configuration register indexes
   localparam logic REG_NODE_ID    = 1'b0;
   localparam logic REG_PEER_TOTAL = 1'b1;

   typedef logic [STAMP_BITS-1:0] stamp_type;
   typedef logic [CNT_BITS-1:0]   count_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_RX_STARTED,
      OP_RX_REQUEST,
      OP_RX_DROP,
      OP_RX_REPLY,
      OP_RX_DONE,
      OP_REQUEST,
      OP_RELEASE,
      OP_STARTED,
      OP_DONE
   } op_code_type;

   typedef struct packed {
      op_code_type code;
      stamp_type   stamp;
      logic [3:0]  sender;
   } op_type;

   typedef struct packed {
      logic [3:0] node_id;
      logic [3:0] peer_total;
   } cfg_type;

   typedef struct packed {
      logic        send_valid;
      logic [1:0]  send_kind;
      logic        send_to_all;
      logic [3:0]  dest;
      logic [15:0] send_stamp;
      logic [15:0] clock_now;
      logic        all_started;
      logic        all_replied;
      logic        all_done;
      logic        last;
   } rsp_type;

   function automatic count_type sat_inc(input count_type c);
      return (c == CNT_MAX) ? c : count_type'(c + 1'b1);
   endfunction

endpackage

// ----- sv/lmn_req_if.sv -----
interface lmn_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [1:0]  msg_type;
   logic [15:0] msg_stamp;
   logic [3:0]  sender;

   modport source(output valid, output cmd, output msg_type, output msg_stamp,
                  output sender, input ready);
   modport sink(input valid, input cmd, input msg_type, input msg_stamp,
                input sender, output ready);
endinterface

// ----- sv/lmn_rsp_if.sv -----
interface lmn_rsp_if;
   logic        valid;
   logic        ready;
   logic        send_valid;
   logic [1:0]  send_kind;
   logic        send_to_all;
   logic [3:0]  dest;
   logic [15:0] send_stamp;
   logic [15:0] clock_now;
   logic        all_started;
   logic        all_replied;
   logic        all_done;
   logic        last;

   modport source(output valid, output send_valid, output send_kind,
                  output send_to_all, output dest, output send_stamp,
                  output clock_now, output all_started, output all_replied,
                  output all_done, output last, input ready);
   modport sink(input valid, input send_valid, input send_kind,
                input send_to_all, input dest, input send_stamp,
                input clock_now, input all_started, input all_replied,
                input all_done, input last, output ready);
endinterface

// ----- sv/lmn_front.sv -----
module lmn_front (
   input  logic            clock,
   input  logic            reset,
   lmn_req_if.sink         req_chan,
   output logic            op_valid,
   output lmn_pkg::op_type op_data,
   input  logic            op_take
);
   import lmn_pkg::*;

   op_type                q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]    count_ff, count_in;
   op_type                dec;
   logic                  push;
   logic                  pop;

   // classify the incoming command
   always_comb begin
      dec.stamp  = stamp_type'(req_chan.msg_stamp);
      dec.sender = req_chan.sender;
      unique case (req_chan.cmd)
         CMD_RECEIVE: begin
            unique case (req_chan.msg_type)
               MSG_STARTED: dec.code = OP_RX_STARTED;
               MSG_REQUEST: dec.code = (int'(req_chan.sender) > ID_LIMIT) ?
                                       OP_RX_DROP : OP_RX_REQUEST;
               MSG_REPLY:   dec.code = OP_RX_REPLY;
               default:     dec.code = OP_RX_DONE;
            endcase
         end
         CMD_REQUEST: dec.code = OP_REQUEST;
         CMD_RELEASE: dec.code = OP_RELEASE;
         CMD_STARTED: dec.code = OP_STARTED;
         CMD_DONE:    dec.code = OP_DONE;
         default:     dec.code = OP_NOP;
      endcase
   end

   assign req_chan.ready = (count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign op_valid       = (count_ff != '0);
   assign pop            = op_take && op_valid;
   assign op_data        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ----- sv/lmn_back.sv -----
module lmn_back (
   input  logic             clock,
   input  logic             reset,
   input  lmn_pkg::cfg_type cfg,
   input  logic             op_valid,
   input  lmn_pkg::op_type  op_data,
   output logic             op_take,
   lmn_rsp_if.source        rsp_chan
);
   import lmn_pkg::*;

   stamp_type             clk_ff, clk_in;
   stamp_type             own_ff, own_in;
   logic                  req_ff, req_in;
   logic [MAP_BITS-1:0]   map_ff, map_in;
   count_type             rep_ff, rep_in;
   count_type             sta_ff, sta_in;
   count_type             don_ff, don_in;
   logic                  walk_ff, walk_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   logic                  slot_free;
   logic                  fire;
   logic                  snd;
   logic [1:0]            snd_kind;
   logic                  snd_all;
   logic [3:0]            snd_dest;
   logic                  snd_last;
   logic [IDX_BITS-1:0]   pick_idx;
   logic [MAP_BITS-1:0]   map_clr;
   stamp_type             raised;
   logic                  answer;

   // lowest deferred id goes first
   always_comb begin
      pick_idx = '0;
      for (int i = MAP_BITS - 1; i >= 0; i--) begin
         if (map_ff[i]) begin
            pick_idx = IDX_BITS'(i);
         end
      end
   end
   assign map_clr = map_ff & ~(MAP_BITS'(1) << pick_idx);

   assign raised = ((clk_ff < op_data.stamp) ? op_data.stamp : clk_ff) + 1'b1;
   assign answer = !req_ff || (op_data.stamp < own_ff) ||
                   ((op_data.stamp == own_ff) && (op_data.sender < cfg.node_id));

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      clk_in   = clk_ff;
      own_in   = own_ff;
      req_in   = req_ff;
      map_in   = map_ff;
      rep_in   = rep_ff;
      sta_in   = sta_ff;
      don_in   = don_ff;
      walk_in  = walk_ff;
      op_take  = 1'b0;
      fire     = 1'b0;
      snd      = 1'b0;
      snd_kind = MSG_STARTED;
      snd_all  = 1'b0;
      snd_dest = '0;
      snd_last = 1'b1;

      if (slot_free) begin
         if (walk_ff) begin
            fire     = 1'b1;
            clk_in   = clk_ff + 1'b1;
            map_in   = map_clr;
            snd      = 1'b1;
            snd_kind = MSG_REPLY;
            snd_dest = 4'(pick_idx);
            snd_last = (map_clr == '0);
            walk_in  = (map_clr != '0);
         end else if (op_valid) begin
            op_take = 1'b1;
            fire    = 1'b1;
            unique case (op_data.code)
               OP_RX_STARTED: begin
                  clk_in = raised;
                  sta_in = sat_inc(sta_ff);
               end
               OP_RX_REQUEST: begin
                  if (answer) begin
                     clk_in   = raised + 1'b1;
                     snd      = 1'b1;
                     snd_kind = MSG_REPLY;
                     snd_dest = op_data.sender;
                  end else begin
                     clk_in = raised;
                     map_in = map_ff | (MAP_BITS'(1) << IDX_BITS'(op_data.sender));
                  end
               end
               OP_RX_DROP: clk_in = raised;
               OP_RX_REPLY: begin
                  clk_in = raised;
                  rep_in = sat_inc(rep_ff);
               end
               OP_RX_DONE: begin
                  clk_in = raised;
                  don_in = sat_inc(don_ff);
               end
               OP_REQUEST: begin
                  clk_in   = clk_ff + 1'b1;
                  own_in   = clk_ff + 1'b1;
                  req_in   = 1'b1;
                  rep_in   = count_type'(1);
                  snd      = 1'b1;
                  snd_kind = MSG_REQUEST;
                  snd_all  = 1'b1;
               end
               OP_RELEASE: begin
                  req_in = 1'b0;
                  // first deferred reply goes out now, the rest by walking
                  if (map_ff != '0) begin
                     clk_in   = clk_ff + 1'b1;
                     map_in   = map_clr;
                     snd      = 1'b1;
                     snd_kind = MSG_REPLY;
                     snd_dest = 4'(pick_idx);
                     snd_last = (map_clr == '0);
                     walk_in  = (map_clr != '0);
                  end
               end
               OP_STARTED: begin
                  sta_in   = sat_inc(sta_ff);
                  clk_in   = clk_ff + 1'b1;
                  snd      = 1'b1;
                  snd_kind = MSG_STARTED;
                  snd_all  = 1'b1;
               end
               OP_DONE: begin
                  don_in   = sat_inc(don_ff);
                  clk_in   = clk_ff + 1'b1;
                  snd      = 1'b1;
                  snd_kind = MSG_DONE;
                  snd_all  = 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      rsp_in.send_valid  = snd;
      rsp_in.send_kind   = snd ? snd_kind : 2'd0;
      rsp_in.send_to_all = snd && snd_all;
      rsp_in.dest        = (snd && !snd_all) ? snd_dest : 4'd0;
      rsp_in.send_stamp  = snd ? 16'(clk_in) : 16'd0;
      rsp_in.clock_now   = 16'(clk_in);
      rsp_in.all_started = (sta_in >= count_type'(cfg.peer_total));
      rsp_in.all_replied = (rep_in >= count_type'(cfg.peer_total));
      rsp_in.all_done    = (don_in >= count_type'(cfg.peer_total));
      rsp_in.last        = snd_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff       <= '0;
         own_ff       <= '0;
         req_ff       <= 1'b0;
         map_ff       <= '0;
         rep_ff       <= '0;
         sta_ff       <= '0;
         don_ff       <= '0;
         walk_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clk_ff  <= clk_in;
         own_ff  <= own_in;
         req_ff  <= req_in;
         map_ff  <= map_in;
         rep_ff  <= rep_in;
         sta_ff  <= sta_in;
         don_ff  <= don_in;
         walk_ff <= walk_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.send_valid  = rsp_ff.send_valid;
   assign rsp_chan.send_kind   = rsp_ff.send_kind;
   assign rsp_chan.send_to_all = rsp_ff.send_to_all;
   assign rsp_chan.dest        = rsp_ff.dest;
   assign rsp_chan.send_stamp  = rsp_ff.send_stamp;
   assign rsp_chan.clock_now   = rsp_ff.clock_now;
   assign rsp_chan.all_started = rsp_ff.all_started;
   assign rsp_chan.all_replied = rsp_ff.all_replied;
   assign rsp_chan.all_done    = rsp_ff.all_done;
   assign rsp_chan.last        = rsp_ff.last;

endmodule

// ----- sv/lamport_mutex_node.sv -----
// Path: a command is written into the queue when it transfers, then its result goes into
//   the output register of the executing stage.
// Throughput: one command per cycle while the receiver takes results; a release with k
//   deferred peers holds the executing stage for k replies, one per cycle off the bitmap.
// Reset: synchronous, active high; clears clock, counters, deferred bitmap and queue,
//   and sets node_id and peer_total to 1. No clearing pass afterward.
module lamport_mutex_node (
   input  logic       clock,
   input  logic       reset,
   lmn_req_if.sink    req_chan,
   lmn_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [3:0] csr_wdata
);
   import lmn_pkg::*;

   logic [3:0] node_id_ff;
   logic [3:0] peer_total_ff;
   cfg_type    cfg;
   logic       op_valid;
   op_type     op_data;
   logic       op_take;

   // Config regs: the user must write them only while the node is quiet (the block
   // does not enforce it), so the back end reads them directly without any shadowing.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff    <= 4'd1;
         peer_total_ff <= 4'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_NODE_ID:    node_id_ff    <= csr_wdata;
            REG_PEER_TOTAL: peer_total_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.node_id    = node_id_ff;
   assign cfg.peer_total = peer_total_ff;

   // Front: takes each transfer, turns cmd/msg_type into one op code
   // (out-of-range request senders are tagged as drops here), and queues it.
   lmn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .op_valid (op_valid),
      .op_data  (op_data),
      .op_take  (op_take)
   );

   // Back: holds the Lamport clock, request stamp, deferred bitmap and the
   // saturating counters; runs one op (or one release reply) per cycle into
   // its output register, and only pulls from the queue when that register
   // frees up and no release walk is pending.
   lmn_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .op_valid (op_valid),
      .op_data  (op_data),
      .op_take  (op_take),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- verif/lamport_mutex_node_tb.sv -----
module lamport_mutex_node_tb;
   import lmn_pkg::*;

   // commands the block must treat as no-ops
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   localparam int ERR_SHOWN    = 10;    // mismatches printed in full
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int PHASE_ITEMS  = 77;    // random transfers per phase
   localparam int SETTLE       = 4;     // cycles past the last result
   localparam int RUN_LIMIT    = 1000000;

   // Mirror of one node: Lamport clock, own request, deferred peers and the
   // three saturating counters. Every accepted command is turned into the
   // messages it should produce; every result is checked against the oldest.
   class node_mirror;
      stamp_type           clk_val;
      stamp_type           my_stamp;
      logic                in_section;
      logic [MAP_BITS-1:0] deferred;
      count_type           replies;
      count_type           starts;
      count_type           dones;
      logic [3:0]          my_id;
      logic [3:0]          peers;
      rsp_type             due_msgs[$];
      int                  faults;

      function new();
         clk_val    = '0;
         my_stamp   = '0;
         in_section = 1'b0;
         deferred   = '0;
         replies    = '0;
         starts     = '0;
         dones      = '0;
         my_id      = 4'd1;
         peers      = 4'd1;
         faults     = 0;
      endfunction

      function void set_reg(logic idx, logic [3:0] value);
         if (idx == REG_NODE_ID) begin
            my_id = value;
         end else begin
            peers = value;
         end
      endfunction

      function count_type bump(count_type c);
         return (c == '1) ? c : count_type'(c + 1'b1);
      endfunction

      function void tick();
         clk_val = stamp_type'(clk_val + 1'b1);
      endfunction

      function rsp_type compose(logic sends, logic [1:0] kind, logic to_all, logic [3:0] to);
         rsp_type m;
         m = '0;
         if (sends) begin
            m.send_valid  = 1'b1;
            m.send_kind   = kind;
            m.send_to_all = to_all;
            m.dest        = to_all ? 4'd0 : to;
            m.send_stamp  = clk_val;
         end
         m.clock_now   = clk_val;
         m.all_started = (starts  >= {1'b0, peers});
         m.all_replied = (replies >= {1'b0, peers});
         m.all_done    = (dones   >= {1'b0, peers});
         return m;
      endfunction

      function void take_command(logic [2:0] cmd, logic [1:0] mt, stamp_type st,
                                 logic [3:0] sd);
         rsp_type batch[$];
         rsp_type tail;
         case (cmd)
            CMD_RECEIVE: begin
               if (clk_val < st) clk_val = st;
               tick();
               case (mt)
                  MSG_STARTED: starts = bump(starts);
                  MSG_REQUEST: begin
                     if (int'(sd) <= ID_LIMIT) begin
                        if (!in_section || st < my_stamp ||
                            (st == my_stamp && sd < my_id)) begin
                           tick();
                           batch.push_back(compose(1'b1, MSG_REPLY, 1'b0, sd));
                        end else begin
                           deferred[sd] = 1'b1;
                        end
                     end
                  end
                  MSG_REPLY:   replies = bump(replies);
                  default:     dones = bump(dones);
               endcase
            end
            CMD_REQUEST: begin
               tick();
               my_stamp   = clk_val;
               in_section = 1'b1;
               replies    = count_type'(1);
               batch.push_back(compose(1'b1, MSG_REQUEST, 1'b1, 4'd0));
            end
            CMD_RELEASE: begin
               in_section = 1'b0;
               for (int id = 0; id < MAP_BITS; id++) begin
                  if (deferred[id]) begin
                     tick();
                     deferred[id] = 1'b0;
                     batch.push_back(compose(1'b1, MSG_REPLY, 1'b0, 4'(id)));
                  end
               end
            end
            CMD_STARTED: begin
               starts = bump(starts);
               tick();
               batch.push_back(compose(1'b1, MSG_STARTED, 1'b1, 4'd0));
            end
            CMD_DONE: begin
               dones = bump(dones);
               tick();
               batch.push_back(compose(1'b1, MSG_DONE, 1'b1, 4'd0));
            end
            default: ;
         endcase
         if (batch.size() == 0) batch.push_back(compose(1'b0, MSG_STARTED, 1'b0, 4'd0));
         tail = batch.pop_back();
         tail.last = 1'b1;
         batch.push_back(tail);
         foreach (batch[i]) due_msgs.push_back(batch[i]);
      endfunction

      function string describe(rsp_type m);
         return $sformatf("sv=%0b kind=%0d all=%0b dest=%0d stamp=%h clk=%h st/rp/dn=%0b%0b%0b last=%0b",
                          m.send_valid, m.send_kind, m.send_to_all, m.dest, m.send_stamp,
                          m.clock_now, m.all_started, m.all_replied, m.all_done, m.last);
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         logic    bad;
         if (due_msgs.size() == 0) begin
            faults++;
            if (faults <= ERR_SHOWN) $display("unexpected result: %s", describe(got));
            return;
         end
         want = due_msgs.pop_front();
         bad = (got.send_valid  !== want.send_valid)  || (got.send_kind   !== want.send_kind)   ||
               (got.send_to_all !== want.send_to_all) || (got.dest        !== want.dest)        ||
               (got.send_stamp  !== want.send_stamp)  || (got.clock_now   !== want.clock_now)   ||
               (got.all_started !== want.all_started) || (got.all_replied !== want.all_replied) ||
               (got.all_done    !== want.all_done)    || (got.last        !== want.last);
         if (bad) begin
            faults++;
            if (faults <= ERR_SHOWN) begin
               $display("result differs at %0t", $realtime);
               $display("  expected: %s", describe(want));
               $display("  actual:   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [3:0] csr_wdata;

   lmn_req_if req_chan();
   lmn_rsp_if rsp_chan();

   lamport_mutex_node u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   node_mirror mirror = new();

   // idle percentages, owned by the stimulus process
   int send_idle;
   int rcv_idle;
   int items_sent;
   // long hold-off handshake: stimulus bumps holds_asked, receiver answers
   int holds_asked;
   int holds_done;
   int hold_left;

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Result side: check every transfer, then pick ready for the next edge.
   // A pending long hold-off overrides the random idling.
   // ------------------------------------------------------------------
   function automatic rsp_type sample_rsp();
      rsp_type m;
      m.send_valid  = rsp_chan.send_valid;
      m.send_kind   = rsp_chan.send_kind;
      m.send_to_all = rsp_chan.send_to_all;
      m.dest        = rsp_chan.dest;
      m.send_stamp  = rsp_chan.send_stamp;
      m.clock_now   = rsp_chan.clock_now;
      m.all_started = rsp_chan.all_started;
      m.all_replied = rsp_chan.all_replied;
      m.all_done    = rsp_chan.all_done;
      m.last        = rsp_chan.last;
      return m;
   endfunction

   initial begin
      holds_done = 0;
      hold_left  = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) mirror.match_result(sample_rsp());
         if (holds_done != holds_asked) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rcv_idle);
         end
      end
   end

   // ------------------------------------------------------------------
   // Command side
   // ------------------------------------------------------------------

   // Offer one command; valid stays up afterward unless a gap is rolled next
   // time, so back-to-back transfers never toggle valid within one step.
   task automatic offer(input logic [2:0] cmd, input logic [1:0] mt, input stamp_type st,
                        input logic [3:0] sd);
      if ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.cmd       <= cmd;
      req_chan.msg_type  <= mt;
      req_chan.msg_stamp <= st;
      req_chan.sender    <= sd;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      mirror.take_command(cmd, mt, st, sd);
      items_sent++;
   endtask

   // local commands ignore the message fields; fill them with noise
   task automatic offer_plain(input logic [2:0] cmd);
      offer(cmd, 2'($urandom), 16'($urandom), 4'($urandom));
   endtask

   // registers only change with nothing in flight
   task automatic set_regs(input logic [3:0] id, input logic [3:0] total);
      csr_we    <= 1'b1;
      csr_index <= REG_NODE_ID;
      csr_wdata <= id;
      @(posedge clock);
      mirror.set_reg(REG_NODE_ID, id);
      csr_index <= REG_PEER_TOTAL;
      csr_wdata <= total;
      @(posedge clock);
      mirror.set_reg(REG_PEER_TOTAL, total);
      csr_we <= 1'b0;
   endtask

   // drop valid and wait until every predicted message has come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (mirror.due_msgs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // stamps clustered around the interesting points: the clock, our own request stamp
   // (ties), the wrap point, small values near zero, and anywhere at all
   function automatic stamp_type pick_stamp();
      int sel;
      sel = $urandom_range(4);
      case (sel)
         0: return stamp_type'($urandom_range(65535));
         1: return stamp_type'(mirror.clk_val + $urandom_range(8) - 4);
         2: return stamp_type'(mirror.my_stamp + $urandom_range(2) - 1);
         3: return stamp_type'(16'hFFFF - $urandom_range(3));
         default: return stamp_type'($urandom_range(15));
      endcase
   endfunction

   task automatic directed_items();
      offer(CMD_RECEIVE, MSG_STARTED, 16'h0000, 4'd0);
      // huge stamp: clock goes to max+1 and wraps to zero
      offer(CMD_RECEIVE, MSG_REPLY, 16'hFFFF, 4'd15);
      // idle node answers at once
      offer(CMD_RECEIVE, MSG_REQUEST, 16'h0010, 4'd3);
      offer_plain(CMD_STARTED);
      offer_plain(CMD_DONE);
      offer(CMD_RECEIVE, MSG_DONE, 16'h0007, 4'd4);
      offer(CMD_RECEIVE, MSG_STARTED, 16'h0002, 4'd6);   // started count hits peer_total
      offer_plain(CMD_DONE);                             // done count hits peer_total
      offer_plain(CMD_REQUEST);
      // later request defers; tie with lower id answers; tie with higher or
      // equal id defers; older request answers
      offer(CMD_RECEIVE, MSG_REQUEST, stamp_type'(mirror.my_stamp + 20), 4'd2);
      offer(CMD_RECEIVE, MSG_REQUEST, mirror.my_stamp, 4'd1);
      offer(CMD_RECEIVE, MSG_REQUEST, mirror.my_stamp, 4'd9);
      offer(CMD_RECEIVE, MSG_REQUEST, mirror.my_stamp, mirror.my_id);
      offer(CMD_RECEIVE, MSG_REQUEST, stamp_type'(mirror.my_stamp - 1), 4'd15);
      offer(CMD_RECEIVE, MSG_REPLY, 16'h0000, 4'd7);
      offer(CMD_RECEIVE, MSG_REPLY, 16'h0001, 4'd8);     // grant
      // request while already requesting restarts it
      offer_plain(CMD_REQUEST);
      offer(CMD_RECEIVE, MSG_REQUEST, stamp_type'(mirror.my_stamp + 1), 4'd0);
      offer_plain(CMD_RELEASE);                          // replies in ascending id order
      offer_plain(CMD_RELEASE);                          // nothing deferred, not requesting
      offer_plain(CMD_SPARE_LO);
      offer_plain(CMD_SPARE_LO + 3'd1);
      offer_plain(CMD_SPARE_HI);
   endtask

   // Mostly protocol-shaped traffic. Now and then a full contention burst:
   // own request, a later request from every id, then a release that sends
   // the widest reply train.
   task automatic random_item();
      int         pick;
      int         first;
      logic [3:0] sd;
      pick = $urandom_range(99);
      if (pick < 3) begin
         offer_plain(CMD_REQUEST);
         first = $urandom_range(15);
         for (int n = 0; n < MAP_BITS; n++) begin
            sd = 4'(first + n);
            offer(CMD_RECEIVE, MSG_REQUEST, stamp_type'(mirror.my_stamp + 1 + $urandom_range(40)),
                  sd);
         end
         offer_plain(CMD_RELEASE);
      end else if (pick < 48) begin
         offer(CMD_RECEIVE, 2'($urandom), pick_stamp(), 4'($urandom));
      end else if (pick < 60) begin
         offer_plain(CMD_REQUEST);
      end else if (pick < 72) begin
         offer_plain(CMD_RELEASE);
      end else if (pick < 82) begin
         offer_plain(CMD_STARTED);
      end else if (pick < 92) begin
         offer_plain(CMD_DONE);
      end else if (pick < 96) begin
         offer_plain(3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)));
      end else begin
         offer(CMD_RECEIVE, MSG_REQUEST, mirror.my_stamp, 4'($urandom));
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence: reset, directed items, then random phases under
   // changing registers and idle mixes. One phase runs with no idling and
   // a long receiver hold-off so the input side backs up.
   // ------------------------------------------------------------------
   logic [3:0] ids_by_phase   [6] = '{4'd15, 4'd1, 4'd8, 4'd15, 4'd2, 4'd11};
   logic [3:0] totals_by_phase[6] = '{4'd15, 4'd1, 4'd4, 4'd1, 4'd15, 4'd6};

   initial begin
      int target;
      send_idle   = 25;
      rcv_idle    = 77;
      items_sent  = 0;
      holds_asked = 0;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= REG_NODE_ID;
      csr_wdata          <= 4'd0;
      req_chan.valid     <= 1'b0;
      req_chan.cmd       <= CMD_RECEIVE;
      req_chan.msg_type  <= MSG_STARTED;
      req_chan.msg_stamp <= '0;
      req_chan.sender    <= 4'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_regs(4'd5, 4'd3);
      directed_items();
      drain();

      for (int p = 0; p < 6; p++) begin
         set_regs(ids_by_phase[p], totals_by_phase[p]);
         case (p % 3)
            0: begin send_idle = 25; rcv_idle = 77; end
            1: begin send_idle = 77; rcv_idle = 25; end
            default: begin send_idle = 0; rcv_idle = 0; end
         endcase
         if (p == 5) holds_asked++;
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) random_item();
         drain();
      end

      repeat (10) @(posedge clock);
      if (mirror.faults == 0 && mirror.due_msgs.size() == 0) begin
         $display("lamport_mutex_node: match");
      end else begin
         $display("lamport_mutex_node: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT);
      $display("lamport_mutex_node: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/lmn_pkg.sv
sv/lmn_req_if.sv
sv/lmn_rsp_if.sv
sv/lmn_front.sv
sv/lmn_back.sv
sv/lamport_mutex_node.sv
verif/lamport_mutex_node_tb.sv
